@@ design/spiral_trajectory_generator_defines.svh @@
// assertion macros for the spiral trajectory generator
`ifndef SPIRAL_TRAJECTORY_GENERATOR_DEFINES_SVH
`define SPIRAL_TRAJECTORY_GENERATOR_DEFINES_SVH

// property must hold whenever reset is low
`define STG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked also during reset
`define STG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/stg_pkg.sv @@
// types and constants for the spiral trajectory generator
package stg_pkg;

  localparam int NUM_REGS = 8;

  typedef enum logic [2:0] {
    REG_ANG_SPEED    = 3'd0,
    REG_IN_SPEED     = 3'd1,
    REG_RISE_SPEED   = 3'd2,
    REG_MIN_RADIUS   = 3'd3,
    REG_MAX_HEIGHT   = 3'd4,
    REG_START_RADIUS = 3'd5,
    REG_START_HEIGHT = 3'd6,
    REG_ORIENTATION  = 3'd7
  } reg_idx_t;

  // cordic gain compensation, q1.15
  localparam logic signed [17:0] GAIN_Q15 = 18'sd19898;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_UPD   = 7'b0000100,
    S_ROT   = 7'b0001000,
    S_QUAD  = 7'b0010000,
    S_PLACE = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
      5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
      5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
      5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat_q15(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) r = 16'sh7fff;
    else if (v < -20'sd32768) r = -16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

@@ design/spiral_trajectory_generator.sv @@
// spiral trajectory generator top level
//
//  channel | signals                                   | dir
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | in
//  in      | in_valid in_ready delta_time pivot_* restart | in
//  out     | out_valid out_ready pos_* reached_min_radius | out
//
// a request is taken in idle and passes through the rate products, the
// state update, the quadrant step, the cordic rotations (one rotation per
// cycle on a shared add/sub unit) and the two placements; the shared 33x33
// multiplier serves the three rate products and the two placements. a new
// request is taken only in idle, once the last result has left the last step.
// rst is synchronous; it clears control, the configuration and the spiral state.
// a stalled result holds in the output registers; the next request is
// still taken and waits in the last step until the result is taken.
`include "spiral_trajectory_generator_defines.svh"

module spiral_trajectory_generator #(
  parameter int CORDIC_STEPS = 16,
  parameter int PHASE_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        delta_time,
  input  logic signed [31:0] pivot_x,
  input  logic signed [31:0] pivot_y,
  input  logic signed [31:0] pivot_z,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic               reached_min_radius
);

  localparam logic [20:0] FULL_TURN = 21'(1) << PHASE_BITS;
  localparam logic [4:0]  LAST_STEP = 5'(CORDIC_STEPS - 1);

  // configuration registers
  logic [19:0]        ang_speed;
  logic [23:0]        in_speed;
  logic [23:0]        rise_speed;
  logic signed [31:0] min_radius;
  logic signed [31:0] max_height;
  logic [30:0]        start_radius;
  logic signed [31:0] start_height;
  logic               orientation;

  // spiral state
  logic [20:0]        phase;
  logic signed [31:0] radius;
  logic signed [31:0] height;

  // request latch
  logic [15:0]        dt;
  logic signed [31:0] px, py, pz;
  logic               flag;

  stg_pkg::state_t    state;
  logic [4:0]         cnt;

  // shared multiplier, one product per cycle, registered
  logic [31:0]        mul_a;
  logic signed [32:0] mul_ax;
  logic signed [32:0] mul_b;
  logic signed [64:0] mul_p;
  logic signed [64:0] prod;

  logic [39:0]        d_phase, d_rad, d_rise;

  // cordic
  logic signed [19:0] cx, cy;
  logic signed [33:0] cz;
  logic [1:0]         quad;
  logic signed [15:0] cosv, sinv;
  logic signed [31:0] off_c;
  logic signed [31:0] off_s;

  assign cfg_ready = (state == stg_pkg::S_IDLE) && !out_valid;
  assign in_ready  = (state == stg_pkg::S_IDLE) && !cfg_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ang_speed <= '0; in_speed <= '0; rise_speed <= '0;
      min_radius <= '0; max_height <= '0; start_radius <= '0;
      start_height <= '0; orientation <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (stg_pkg::reg_idx_t'(cfg_index))
        stg_pkg::REG_ANG_SPEED:    ang_speed <= cfg_data[19:0];
        stg_pkg::REG_IN_SPEED:     in_speed <= cfg_data[23:0];
        stg_pkg::REG_RISE_SPEED:   rise_speed <= cfg_data[23:0];
        stg_pkg::REG_MIN_RADIUS:   min_radius <= cfg_data;
        stg_pkg::REG_MAX_HEIGHT:   max_height <= cfg_data;
        stg_pkg::REG_START_RADIUS: start_radius <= cfg_data[30:0];
        stg_pkg::REG_START_HEIGHT: start_height <= cfg_data;
        stg_pkg::REG_ORIENTATION:  orientation <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      stg_pkg::S_MUL: begin
        mul_a = {16'h0, dt};
        case (cnt[1:0])
          2'd0: mul_b = {13'h0, ang_speed};
          2'd1: mul_b = {9'h0, in_speed};
          default: mul_b = {9'h0, rise_speed};
        endcase
      end
      stg_pkg::S_PLACE: begin
        mul_a = radius;
        mul_b = (cnt[0] == 1'b0) ? 33'(cosv) : 33'(sinv);
      end
      default: ;
    endcase
  end
  // radius is signed: sign-extend mul_a in placement
  assign mul_ax = (state == stg_pkg::S_PLACE) ? {mul_a[31], mul_a} : {1'b0, mul_a};
  assign mul_p  = 65'(mul_ax) * 65'(mul_b);

  logic [4:0]         sh;
  logic signed [19:0] xs, ys;
  logic signed [33:0] at;
  logic [31:0]        a_ph;
  logic [1:0]         q_calc;
  logic signed [32:0] h_sum;
  logic signed [32:0] r_sum;

  always_comb begin
    sh = cnt;
    xs = cx >>> sh;
    ys = cy >>> sh;
    at = 34'(stg_pkg::atan_lut(cnt));
    a_ph = 32'(phase[PHASE_BITS-1:0]) << (32 - PHASE_BITS);
    q_calc = 2'((a_ph + 32'h20000000) >> 30);
    h_sum = 33'(height) + 33'(d_rise[39:16]);
    r_sum = 33'(radius) - 33'(d_rad[39:16]);
    case (quad)
      2'd0: begin cosv = stg_pkg::sat_q15(cx);  sinv = stg_pkg::sat_q15(cy);  end
      2'd1: begin cosv = stg_pkg::sat_q15(-cy); sinv = stg_pkg::sat_q15(cx);  end
      2'd2: begin cosv = stg_pkg::sat_q15(-cx); sinv = stg_pkg::sat_q15(-cy); end
      default: begin cosv = stg_pkg::sat_q15(cy); sinv = stg_pkg::sat_q15(-cx); end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stg_pkg::S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
      phase <= '0;
      radius <= '0;
      height <= '0;
    end else begin
      if (out_valid && out_ready && state != stg_pkg::S_OUT) out_valid <= 1'b0;
      case (state)
        stg_pkg::S_IDLE: begin
          // restart reloads the start state before the step
          if (in_valid && in_ready) begin
            dt <= delta_time; px <= pivot_x; py <= pivot_y; pz <= pivot_z;
            if (restart) begin
              radius <= 32'(start_radius);
              height <= start_height;
              phase <= '0;
              flag <= $signed(32'(start_radius)) <= min_radius;
            end else begin
              flag <= radius <= min_radius;
            end
            cnt <= '0;
            state <= stg_pkg::S_MUL;
          end
        end
        stg_pkg::S_MUL: begin
          // each product lands from the output register in the cycle after its operands
          if (cnt == 5'd1) d_phase <= prod[39:0];
          if (cnt == 5'd2) d_rad <= prod[39:0];
          if (cnt == 5'd3) begin
            d_rise <= prod[39:0];
            state <= stg_pkg::S_UPD;
          end
          cnt <= cnt + 5'd1;
        end
        stg_pkg::S_UPD: begin
          phase <= (phase >= FULL_TURN) ? d_phase[36:16] : phase + d_phase[36:16];
          if (radius >= 0) radius <= r_sum[31:0];
          if (height <= max_height)
            height <= (h_sum > 33'sh07fffffff) ? 32'sh7fffffff : h_sum[31:0];
          state <= stg_pkg::S_QUAD;
          cnt <= '0;
        end
        stg_pkg::S_QUAD: begin
          quad <= q_calc;
          cz <= 34'($signed(a_ph - {q_calc, 30'h0}));
          cx <= 20'(stg_pkg::GAIN_Q15);
          cy <= '0;
          cnt <= '0;
          state <= stg_pkg::S_ROT;
        end
        stg_pkg::S_ROT: begin
          if (cz >= 0) begin
            cx <= cx - ys; cy <= cy + xs; cz <= cz - at;
          end else begin
            cx <= cx + ys; cy <= cy - xs; cz <= cz + at;
          end
          if (cnt == LAST_STEP) begin
            cnt <= '0;
            state <= stg_pkg::S_PLACE;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        stg_pkg::S_PLACE: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd1) begin
            off_c <= prod[46:15];
          end
          if (cnt == 5'd2) begin
            off_s <= prod[46:15];
            state <= stg_pkg::S_OUT;
          end
        end
        stg_pkg::S_OUT: begin
          // wait here while the previous result is still held
          if (!out_valid || out_ready) begin
            if (orientation == 1'b0) begin
              pos_x <= px + off_c;
              pos_y <= py + off_s;
              pos_z <= pz + height;
            end else begin
              pos_x <= px + off_s;
              pos_y <= py + height;
              pos_z <= pz + off_c;
            end
            reached_min_radius <= flag;
            out_valid <= 1'b1;
            state <= stg_pkg::S_IDLE;
          end
        end
        default: state <= stg_pkg::S_IDLE;
      endcase
    end
  end

  // multiplier output register
  always_ff @(posedge clk) begin
    prod <= mul_p;
  end

  `STG_ASSERT(a_onehot, $onehot(state), "state not one-hot")
  `STG_ASSERT(a_busy, (state != stg_pkg::S_IDLE) |-> !in_ready, "ready while busy")
  `STG_ASSERT(a_outv, $rose(out_valid) |-> $past(state == stg_pkg::S_OUT), "stray result")
  `STG_ASSERT_ALWAYS(a_rst, rst |=> !out_valid, "result after reset")

endmodule
